// ===== rtl/core/fwt_pkg.sv =====
`timescale 1ns / 1ps

package fwt_pkg;

   localparam int DataW  = 32;
   localparam int IndexW = 11;
   // A walk position can step one lowest set bit past the highest index.
   localparam int PosW   = IndexW + 1;
   localparam int KindW  = 2;

   localparam logic [IndexW-1:0] SizeReset = 11'd1024;
   localparam int MaxIndex = (1 << IndexW) - 1;

   localparam logic [KindW-1:0] KindAdd   = 2'd0;
   localparam logic [KindW-1:0] KindQuery = 2'd1;
   localparam logic [KindW-1:0] KindClear = 2'd2;

   typedef struct packed {
      logic load;       // capture the accepted item
      logic issue;      // read the entry at the walk position and step on
      logic clr_write;  // zero the entry at the clear counter
      logic rsp_load;   // move the finished sum into the result register
   } cmd_type;

   typedef struct packed {
      logic walk_done;
      logic is_query;
      logic is_clear;
      logic clr_last;
   } status_type;

endpackage

// ===== rtl/core/fenwick_tree_prefix_sum_top.sv =====
`timescale 1ns / 1ps

// Fenwick (binary indexed) tree over SIZE signed 32-bit entries, addressed
// from 1. An add item (tuser 0) adds delta at index and then at each index
// plus its lowest set bit while the index stays within the active size, the
// smaller of the size register and SIZE; it returns nothing, and an index of
// zero or beyond the active size changes nothing. A query item (tuser 1)
// returns the sum of entries 1 through index, the index clamped to the
// active size. A clear item (tuser 2) zeroes the store; tuser 3 is ignored.
// Sums wrap in 32-bit two's complement. The store is one RAM with a
// registered read, read once per cycle along the walk: reads follow each
// other back to back and each add write lands in the cycle after its read.
// A query also passes through a finishing step that moves its sum into
// the output register. With the default 1024-entry store an add walk
// touches at most 11 entries and a query walk at most 10. After reset and
// after each clear item the block zeroes min(SIZE, 2047) entries at one per
// cycle and accepts no item meanwhile; size register writes are always
// taken. A finished query sum sits in an output register, so the next item
// is taken while the result still waits.
module fenwick_tree_prefix_sum_top #(
   parameter int SIZE = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // Input items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [10:0] index, [42:11] delta, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] kind
   // Results.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] prefix_sum
   // Size register write.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_wdata    // size_in_use
);

   import fwt_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The size register is a plain register and never stalls a write.
   assign csr_ready = 1'b1;

   fwt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fwt_dp #(
      .SIZE (SIZE)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_valid (csr_valid),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== rtl/core/fwt_ram.sv =====
`timescale 1ns / 1ps

module fwt_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024,
   parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AddrW-1:0] waddr,
   input  logic [Width-1:0] wdata,
   input  logic             re,
   input  logic [AddrW-1:0] raddr,
   output logic [Width-1:0] rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/fwt_ctrl.sv =====
`timescale 1ns / 1ps

module fwt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  fwt_pkg::status_type status,
   output fwt_pkg::cmd_type    cmd
);

   import fwt_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.is_clear) begin
               state_in = ST_CLEAR;
            end else if (!status.walk_done) begin
               cmd.issue = 1'b1;
            end else begin
               state_in = status.is_query ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/core/fwt_dp.sv =====
`timescale 1ns / 1ps

module fwt_dp #(
   parameter int SIZE = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [47:0]                 req_tdata,
   input  logic [fwt_pkg::KindW-1:0]   req_tuser,
   input  logic                        csr_valid,
   input  logic [fwt_pkg::IndexW-1:0]  csr_wdata,
   input  fwt_pkg::cmd_type            cmd,
   output fwt_pkg::status_type         status,
   output logic [fwt_pkg::DataW-1:0]   rsp_tdata
);

   import fwt_pkg::*;

   localparam int AW = $clog2(SIZE);
   // Entries above the widest size register value are never reached.
   localparam int ClrDepth = (SIZE < MaxIndex) ? SIZE : MaxIndex;

   logic [IndexW-1:0] size_ff;
   logic [IndexW-1:0] limit;
   logic [KindW-1:0]  kind_ff;
   logic [PosW-1:0]   pos_ff, pos_in;
   logic [PosW-1:0]   lowbit;
   logic [DataW-1:0]  delta_ff;
   logic [DataW-1:0]  acc_ff, acc_in;
   logic [DataW-1:0]  rsp_data_ff;
   logic [AW-1:0]     prev_addr_ff;
   logic              rd_vld_ff;
   logic [AW-1:0]     clr_cnt_ff;
   logic [IndexW-1:0] req_index;
   logic [AW-1:0]     rd_addr;
   logic [DataW-1:0]  rd_data;
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [DataW-1:0]  ram_wdata;

   assign req_index = req_tdata[IndexW-1:0];
   assign limit     = ({21'd0, size_ff} < 32'(SIZE)) ? size_ff : IndexW'(SIZE);
   assign lowbit    = pos_ff & (~pos_ff + PosW'(1));
   assign rd_addr   = AW'(pos_ff - PosW'(1));

   always_comb begin
      pos_in = pos_ff;
      if (cmd.load) begin
         if (req_tuser == KindQuery && req_index > limit) begin
            pos_in = {1'b0, limit};
         end else begin
            pos_in = {1'b0, req_index};
         end
      end else if (cmd.issue) begin
         pos_in = (kind_ff == KindAdd) ? pos_ff + lowbit : pos_ff - lowbit;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.load) begin
         acc_in = '0;
      end else if (rd_vld_ff && kind_ff == KindQuery) begin
         acc_in = acc_ff + rd_data;
      end
   end

   // Write port: clearing sweep, or the update of the entry read last cycle.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = prev_addr_ff;
      ram_wdata = rd_data + delta_ff;
      if (cmd.clr_write) begin
         ram_we    = 1'b1;
         ram_waddr = clr_cnt_ff;
         ram_wdata = '0;
      end else if (rd_vld_ff && kind_ff == KindAdd) begin
         ram_we = 1'b1;
      end
   end

   always_comb begin
      status.is_query = (kind_ff == KindQuery);
      status.is_clear = (kind_ff == KindClear);
      status.clr_last = (clr_cnt_ff == AW'(ClrDepth - 1));
      case (kind_ff)
         KindAdd:   status.walk_done = (pos_ff == '0) || (pos_ff > {1'b0, limit});
         KindQuery: status.walk_done = (pos_ff == '0);
         default:   status.walk_done = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff    <= SizeReset;
         rd_vld_ff  <= 1'b0;
         clr_cnt_ff <= '0;
         kind_ff    <= KindAdd;
         pos_ff     <= '0;
      end else begin
         if (csr_valid) begin
            size_ff <= csr_wdata;
         end
         rd_vld_ff <= cmd.issue;
         if (cmd.load) begin
            kind_ff    <= req_tuser;
            clr_cnt_ff <= '0;
         end else if (cmd.clr_write) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         delta_ff <= req_tdata[IndexW +: DataW];
      end
      if (cmd.issue) begin
         prev_addr_ff <= rd_addr;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= acc_ff;
      end
      acc_ff <= acc_in;
   end

   fwt_ram #(
      .Width (DataW),
      .Depth (SIZE),
      .AddrW (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd.issue),
      .raddr (rd_addr),
      .rdata (rd_data)
   );

   assign rsp_tdata = rsp_data_ff;

endmodule
